@@ sv/k_nearest_to_origin_select_macros.svh @@
`ifndef K_NEAREST_TO_ORIGIN_SELECT_MACROS_SVH
`define K_NEAREST_TO_ORIGIN_SELECT_MACROS_SVH

// Same-cycle implication, checked on clk and disabled in reset.
`define KNS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kns check failed");

// Next-cycle implication, checked on clk and disabled in reset.
`define KNS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kns check failed");

`endif

@@ sv/kns_pkg.sv @@
package kns_pkg;

    localparam int MAX_KEEP_DEFAULT = 16;
    localparam int KEEP_W = 5;
    localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic signed [31:0] sq_x;
        logic signed [31:0] sq_y;
    } squares_t;

    typedef struct packed {
        logic [31:0]        d;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } entry_t;

    typedef struct packed {
        entry_t e;
        logic   last;
    } item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } back_state_t;

endpackage

@@ sv/kns_queue.sv @@
module kns_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  kns_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output kns_pkg::item_t pop_item
);

    localparam int PW = (kns_pkg::QUEUE_DEPTH > 1) ? $clog2(kns_pkg::QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(kns_pkg::QUEUE_DEPTH + 1);

    kns_pkg::item_t slot_reg [kns_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FW-1:0]  fill_reg, fill_next;
    logic           do_push, do_pop;

    assign push_ready = (fill_reg != FW'(kns_pkg::QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(kns_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(kns_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        fill_next = fill_reg + FW'(do_push) - FW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ sv/kns_front.sv @@
module kns_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [31:0]    in_data,
    input  logic           in_last,
    output logic           push_valid,
    input  logic           push_ready,
    output kns_pkg::item_t push_item
);

    logic                valid_reg, valid_next;
    logic signed [15:0]  x_reg, y_reg;
    logic                last_reg;
    kns_pkg::squares_t   sq_reg;
    logic signed [15:0]  in_x, in_y;
    logic                take;

    assign in_x       = in_data[15:0];
    assign in_y       = in_data[31:16];
    assign in_ready   = !valid_reg || push_ready;
    assign take       = in_valid && in_ready;
    assign push_valid = valid_reg;

    always_comb
    begin
        push_item.e.x = x_reg;
        push_item.e.y = y_reg;
        push_item.e.d = 32'(sq_reg.sq_x) + 32'(sq_reg.sq_y);
        push_item.last = last_reg;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            x_reg         <= in_x;
            y_reg         <= in_y;
            last_reg      <= in_last;
            sq_reg.sq_x   <= 32'(in_x) * 32'(in_x);
            sq_reg.sq_y   <= 32'(in_y) * 32'(in_y);
        end
    end

endmodule

@@ sv/kns_back.sv @@
`include "k_nearest_to_origin_select_macros.svh"

module kns_back
#(
    parameter int MAX_KEEP = kns_pkg::MAX_KEEP_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [kns_pkg::KEEP_W-1:0] keep_count,
    input  logic                       q_valid,
    output logic                       q_ready,
    input  kns_pkg::item_t             q_item,
    output logic                       out_valid,
    input  logic                       out_ready,
    output kns_pkg::entry_t            out_entry,
    output logic                       out_last
);

    localparam int IW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int CW = $clog2(MAX_KEEP + 1);
    localparam int EW = (CW > kns_pkg::KEEP_W) ? CW : kns_pkg::KEEP_W;

    kns_pkg::entry_t      entry_reg [MAX_KEEP];
    kns_pkg::back_state_t state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        scan_idx_reg, scan_idx_next;
    logic [IW-1:0]        best_idx_reg, best_idx_next;
    kns_pkg::entry_t      best_reg, best_next;
    logic                 emit_reg, emit_next;
    kns_pkg::item_t       cur_reg, cur_next;
    logic                 out_valid_reg, out_valid_next;
    kns_pkg::entry_t      out_entry_reg;
    logic                 out_last_reg;

    logic [EW-1:0]        keep_e, max_e, lim_e;
    logic                 can_add, scanning, take, load_out;
    logic                 do_remove, do_append;
    logic [IW-1:0]        app_idx;
    kns_pkg::entry_t      app_data, cand;

    assign keep_e   = EW'(keep_count);
    assign max_e    = EW'(MAX_KEEP);
    assign lim_e    = (keep_e == '0) ? EW'(1) : ((keep_e > max_e) ? max_e : keep_e);
    assign can_add  = EW'(count_reg) < lim_e;
    assign scanning = scan_idx_reg < count_reg;
    assign cand     = entry_reg[scan_idx_reg[IW-1:0]];

    assign out_valid = out_valid_reg;
    assign out_entry = out_entry_reg;
    assign out_last  = out_last_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kns_pkg::ST_IDLE:
            begin
                if (q_valid && !(can_add && !q_item.last))
                begin
                    state_next = kns_pkg::ST_SCAN;
                end
            end
            kns_pkg::ST_SCAN:
            begin
                if (!scanning)
                begin
                    if (emit_reg)
                    begin
                        state_next = kns_pkg::ST_EMIT;
                    end
                    else if (!cur_reg.last)
                    begin
                        state_next = kns_pkg::ST_IDLE;
                    end
                end
            end
            kns_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = (count_reg == CW'(1)) ? kns_pkg::ST_IDLE : kns_pkg::ST_SCAN;
                end
            end
            default:
            begin
                state_next = kns_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_ready       = 1'b0;
        take          = 1'b0;
        load_out      = 1'b0;
        do_remove     = 1'b0;
        do_append     = 1'b0;
        app_idx       = count_reg[IW-1:0];
        app_data      = cur_reg.e;
        count_next    = count_reg;
        scan_idx_next = scan_idx_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        emit_next     = emit_reg;
        cur_next      = cur_reg;
        unique case (state_reg)
            kns_pkg::ST_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    take          = 1'b1;
                    cur_next      = q_item;
                    scan_idx_next = '0;
                    if (can_add)
                    begin
                        do_append  = 1'b1;
                        app_data   = q_item.e;
                        count_next = count_reg + 1'b1;
                        emit_next  = q_item.last;
                    end
                    else
                    begin
                        emit_next = 1'b0;
                    end
                end
            end
            kns_pkg::ST_SCAN:
            begin
                if (scanning)
                begin
                    if ((scan_idx_reg == '0) || (cand.d > best_reg.d))
                    begin
                        best_next     = cand;
                        best_idx_next = scan_idx_reg[IW-1:0];
                    end
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                else if (!emit_reg)
                begin
                    if (cur_reg.e.d < best_reg.d)
                    begin
                        do_remove = 1'b1;
                        do_append = 1'b1;
                        app_idx   = IW'(count_reg - 1'b1);
                    end
                    if (cur_reg.last)
                    begin
                        emit_next     = 1'b1;
                        scan_idx_next = '0;
                    end
                end
            end
            kns_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out      = 1'b1;
                    do_remove     = 1'b1;
                    count_next    = count_reg - 1'b1;
                    scan_idx_next = '0;
                    if (count_reg == CW'(1))
                    begin
                        emit_next = 1'b0;
                    end
                end
            end
            default:
            begin
                emit_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kns_pkg::ST_IDLE;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            emit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        cur_reg      <= cur_next;
        if (load_out)
        begin
            out_entry_reg <= best_reg;
            out_last_reg  <= (count_reg == CW'(1));
        end
    end

    // Removal closes the gap by moving later arrivals down one place.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_KEEP; i++)
        begin
            if (do_remove && (i + 1 < MAX_KEEP) && (i >= int'(best_idx_reg))
                && (i + 1 < int'(count_reg)))
            begin
                entry_reg[i] <= entry_reg[(i + 1) % MAX_KEEP];
            end
            if (do_append && (i == int'(app_idx)))
            begin
                entry_reg[i] <= app_data;
            end
        end
    end

    `KNS_ASSERT_IMP(a_scan_bound, state_reg == kns_pkg::ST_SCAN, scan_idx_reg <= count_reg)
    `KNS_ASSERT_NXT(a_append_grows, take && can_add, count_reg == CW'($past(count_reg) + 1'b1))
    `KNS_ASSERT_IMP(a_emit_nonempty, state_reg == kns_pkg::ST_EMIT, count_reg != '0)

endmodule

@@ sv/k_nearest_to_origin_select.sv @@
// Channel  | Direction | Transfer content
// s_axis   | in        | tdata: point_x, point_y; tlast: set_end
// m_axis   | out       | tdata: near_x, near_y, dist_sq; tlast: run_last
// cfg      | in        | data: keep_count
//
// A point that fills an empty place is appended directly; a point that must compete
// waits for the one-entry-per-cycle farthest-point scan over the held entries.
// A set end repeats the same scan before each emitted point.
// Reset clears the held count and sets keep_count to 16; no clearing pass is needed.
// A two-entry queue lets the input side keep taking points while results stall.
module k_nearest_to_origin_select
#(
    parameter int MAX_KEEP = kns_pkg::MAX_KEEP_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [31:0]                s_axis_tdata,  // point_x, point_y
    input  logic                       s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [63:0]                m_axis_tdata,  // near_x, near_y, dist_sq
    output logic                       m_axis_tlast,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [kns_pkg::KEEP_W-1:0] cfg_data
);

    logic [kns_pkg::KEEP_W-1:0] keep_count_reg, keep_count_next;
    logic                       push_valid, push_ready, pop_valid, pop_ready;
    kns_pkg::item_t             push_item, pop_item;
    kns_pkg::entry_t            out_entry;

    assign cfg_ready       = 1'b1;
    assign keep_count_next = (cfg_valid && cfg_ready) ? cfg_data : keep_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg <= kns_pkg::KEEP_RESET;
        end
        else
        begin
            keep_count_reg <= keep_count_next;
        end
    end

    kns_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    kns_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    kns_back #(.MAX_KEEP(MAX_KEEP)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .keep_count (keep_count_reg),
        .q_valid    (pop_valid),
        .q_ready    (pop_ready),
        .q_item     (pop_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_entry  (out_entry),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {out_entry.d, out_entry.y, out_entry.x};

endmodule

@@ tb/k_nearest_to_origin_select_tb.sv @@
module k_nearest_to_origin_select_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_KEEP = kns_pkg::MAX_KEEP_DEFAULT;
    localparam int MISMATCH_REPORTS = 10;
    localparam longint CYCLE_LIMIT = 1000000;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
    } point_t;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [31:0]        d;
        logic               last;
    } near_t;

    logic                       clk;
    logic                       rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [31:0]                s_axis_tdata;
    logic                       s_axis_tlast;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [63:0]                m_axis_tdata;
    logic                       m_axis_tlast;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [kns_pkg::KEEP_W-1:0] cfg_data;

    point_t pending_points[$];
    near_t  expected_near[$];
    near_t  held_model[$];
    logic [kns_pkg::KEEP_W-1:0] keep_model;

    int  mismatches;
    int  points_sent;
    int  results_seen;
    int  sets_closed;
    int  hold_off_cycles;
    longint cycle_count;
    int  send_gap;
    int  recv_gap;

    k_nearest_to_origin_select i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic [31:0] squared_distance(logic signed [15:0] x,
                                                     logic signed [15:0] y);
        longint sx;
        longint sy;
        sx = x;
        sy = y;
        return 32'(sx * sx + sy * sy);
    endfunction

    function automatic int farthest_held();
        int best;
        best = 0;
        for (int i = 1; i < held_model.size(); i++)
        begin
            if (held_model[i].d > held_model[best].d)
                best = i;
        end
        return best;
    endfunction

    // Updates the retained set with one point and queues the emitted points on a set end.
    task automatic retain_nearest(point_t p);
        int    k;
        int    f;
        near_t e;
        k = keep_model;
        if (k < 1)
            k = 1;
        if (k > MAX_KEEP)
            k = MAX_KEEP;
        e.x = p.x;
        e.y = p.y;
        e.d = squared_distance(p.x, p.y);
        e.last = 1'b0;
        if (held_model.size() < k)
            held_model = {held_model, e};
        else if (held_model.size() > 0)
        begin
            f = farthest_held();
            if (e.d < held_model[f].d)
            begin
                held_model.delete(f);
                held_model = {held_model, e};
            end
        end
        if (p.last)
        begin
            while (held_model.size() > 0)
            begin
                f = farthest_held();
                e = held_model[f];
                held_model.delete(f);
                e.last = (held_model.size() == 0);
                expected_near = {expected_near, e};
            end
            sets_closed++;
        end
    endtask

    function automatic int short_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tlast <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                retain_nearest(pending_points.pop_front());
                points_sent++;
            end
            if (s_axis_tvalid && !s_axis_tready)
            begin
            end
            else if (send_gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_points.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {pending_points[0].y, pending_points[0].x};
                s_axis_tlast <= pending_points[0].last;
                send_gap <= ($urandom_range(0, 3) == 0) ? short_gap() : 0;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_gap <= 0;
        end
        else if (hold_off_cycles > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_off_cycles--;
        end
        else if (recv_gap > 0)
        begin
            m_axis_tready <= 1'b0;
            recv_gap <= recv_gap - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            recv_gap <= ($urandom_range(0, 3) == 0) ? short_gap() : 0;
        end
    end

    always @(posedge clk)
    begin
        near_t exp_n;
        if (rst_n)
        begin
            cycle_count++;
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (expected_near.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MISMATCH_REPORTS)
                        $display("Unexpected result transfer: data %h last %b",
                                 m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    exp_n = expected_near.pop_front();
                    if (m_axis_tdata[15:0] !== exp_n.x || m_axis_tdata[31:16] !== exp_n.y
                        || m_axis_tdata[63:32] !== exp_n.d || m_axis_tlast !== exp_n.last)
                    begin
                        mismatches++;
                        if (mismatches <= MISMATCH_REPORTS)
                        begin
                            $display("Mismatch: expected x %0d y %0d d %0d last %b,",
                                     exp_n.x, exp_n.y, exp_n.d, exp_n.last);
                            $display("    got x %0d y %0d d %0d last %b",
                                     $signed(m_axis_tdata[15:0]),
                                     $signed(m_axis_tdata[31:16]),
                                     m_axis_tdata[63:32], m_axis_tlast);
                        end
                    end
                end
            end
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles", cycle_count);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic point_t make_point(int x, int y, logic last);
        point_t p;
        p.x = 16'(x);
        p.y = 16'(y);
        p.last = last;
        return p;
    endfunction

    task automatic queue_point(int x, int y, logic last);
        pending_points = {pending_points, make_point(x, y, last)};
    endtask

    function automatic logic signed [15:0] random_coord();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 7)) - 16'sd4;
            1: return 16'sh8000;
            2: return 16'sh7fff;
            3: return 16'($urandom_range(0, 15)) - 16'sd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic wait_idle();
        while (pending_points.size() > 0 || expected_near.size() > 0)
            @(posedge clk);
        repeat (MAX_KEEP * (MAX_KEEP + 4) + 20) @(posedge clk);
    endtask

    task automatic write_keep(logic [kns_pkg::KEEP_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        keep_model = value;
    endtask

    task automatic random_sets(int count);
        int len;
        int i;
        while (count > 0)
        begin
            len = $urandom_range(0, 5) == 0 ? $urandom_range(15, 24) : $urandom_range(1, 8);
            for (i = 0; i < len && count > 0; i++)
            begin
                count--;
                queue_point(random_coord(), random_coord(), i == len - 1 || count == 0);
            end
        end
    endtask

    initial
    begin
        logic [kns_pkg::KEEP_W-1:0] keep_values[7] =
            '{5'd1, 5'd0, 5'd31, 5'd3, 5'd17, 5'd8, 5'd5};
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        keep_model = kns_pkg::KEEP_RESET;
        mismatches = 0;
        points_sent = 0;
        results_seen = 0;
        sets_closed = 0;
        hold_off_cycles = 0;
        cycle_count = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Extremes, ties of equal distance and a short set with the reset keep count.
        queue_point(-32768, -32768, 1'b0);
        queue_point(32767, 32767, 1'b0);
        queue_point(0, 0, 1'b0);
        queue_point(3, 4, 1'b0);
        queue_point(-4, 3, 1'b0);
        queue_point(5, 0, 1'b1);
        queue_point(7, -7, 1'b1);
        wait_idle();

        write_keep(5'd2);
        queue_point(10, 0, 1'b0);
        queue_point(0, 10, 1'b0);
        queue_point(-10, 0, 1'b0);
        queue_point(1, 1, 1'b0);
        queue_point(-32768, 0, 1'b0);
        queue_point(0, -1, 1'b1);
        wait_idle();

        // Lowering keep count in the middle of a set.
        write_keep(5'd4);
        for (int i = 0; i < 4; i++)
            queue_point(i * 3 - 5, 2 - i, 1'b0);
        wait_idle();
        write_keep(5'd1);
        queue_point(1, 0, 1'b0);
        queue_point(100, 100, 1'b1);
        wait_idle();

        write_keep(5'd16);
        hold_off_cycles = 400;
        random_sets(30);
        wait_idle();

        foreach (keep_values[j])
        begin
            write_keep(keep_values[j]);
            random_sets(10);
            wait_idle();
        end

        if (expected_near.size() > 0)
            mismatches++;
        $display("Sent %0d points in %0d sets and checked %0d emitted points.",
                 points_sent, sets_closed, results_seen);
        $display("Keep counts from 0 to 31 were used, with stalls on both sides.");
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+sv
sv/kns_pkg.sv
sv/kns_queue.sv
sv/kns_front.sv
sv/kns_back.sv
sv/k_nearest_to_origin_select.sv
tb/k_nearest_to_origin_select_tb.sv
